// File: rtl/core/vdl_pkg.sv
// ----------------------------------------------------------------------------
// vdl_pkg
// Shared types and constants for the vertex diffuse lighting block.
// ----------------------------------------------------------------------------
`default_nettype none

package vdl_pkg;

    // number of light cells in the chain
    localparam int LIGHT_SLOTS = 3;
    localparam int SLOT_W      = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COUNT = 3'd0;
    // light 0 registers; each further light sits two indexes higher
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_CG0   = 3'd2;

    // 0.1 in Q1.15 and 1.0 in Q1.15
    localparam logic [11:0] AMBIENT_Q15 = 12'd3277;
    localparam logic [15:0] ONE_Q15     = 16'd32768;

    // accumulator wide enough for ambient plus all lights
    localparam int ACC_W = 26;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic        [15:0] base_red;
        logic        [15:0] base_green;
        logic        [15:0] base_blue;
    } in_t;

    typedef struct packed {
        logic [15:0] lit_red;
        logic [15:0] lit_green;
        logic [15:0] lit_blue;
    } out_t;

    // word handed from cell to cell
    typedef struct packed {
        in_t              px;
        logic [ACC_W-1:0] acc_r;
        logic [ACC_W-1:0] acc_g;
        logic [ACC_W-1:0] acc_b;
    } item_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DIFF,
        C_PROD,
        C_SUM,
        C_CHK,
        C_SQRT,
        C_DIVI,
        C_DIV,
        C_HMUL,
        C_DMUL,
        C_OUT
    } cell_state_t;

endpackage

`default_nettype wire

// File: rtl/core/vdl_cell.sv
// ----------------------------------------------------------------------------
// vdl_cell
// One light of the chain: holds its light registers, takes a word from the
// previous cell, adds its diffuse term and hands the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module vdl_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [vdl_pkg::SLOT_W-1:0]      slot_id,
    input  wire logic                            light_on,
    input  wire logic                            cfg_we,
    input  wire logic [vdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vdl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            up_valid,
    output logic                                 up_ready,
    input  wire vdl_pkg::item_t                  up_item,
    output logic                                 dn_valid,
    input  wire logic                            dn_ready,
    output vdl_pkg::item_t                       dn_item
);

    vdl_pkg::cell_state_t state_reg, state_next;

    logic [47:0] pos_reg;
    logic [63:0] cg_reg;
    vdl_pkg::item_t item_reg;

    logic signed [16:0] d_reg  [3];
    logic        [19:0] g_reg  [3];
    logic signed [32:0] pn_reg [3];
    logic        [31:0] pd_reg [3];
    logic signed [34:0] dot_reg;
    logic        [33:0] dd_reg;
    logic        [53:0] rad_reg;
    logic        [29:0] rem_reg;
    logic        [26:0] root_reg;
    logic        [17:0] dvd_reg;
    logic        [27:0] drem_reg;
    logic        [17:0] quo_reg;
    logic        [22:0] h_reg  [3];
    logic        [4:0]  cnt_reg;

    logic [vdl_pkg::CFG_IDX_W-1:0] pos_idx, cg_idx;

    logic signed [15:0] vtx  [3];
    logic signed [15:0] nrm  [3];
    logic        [15:0] base [3];
    logic [vdl_pkg::ACC_W-1:0] acc [3];

    logic signed [16:0] d_c   [3];
    logic        [19:0] g_c   [3];
    logic signed [32:0] pn_c  [3];
    logic signed [33:0] sq_c  [3];
    logic        [37:0] hp_c  [3];
    logic        [38:0] dp_c  [3];
    logic        [31:0] gp_c  [3];
    logic        [29:0] rem_sh;
    logic        [29:0] trial;
    logic        [27:0] drem_sh;
    logic        [43:0] dividend;

    // register decode for this slot
    assign pos_idx = vdl_pkg::CFG_IDX_W'({slot_id, 1'b0}) + vdl_pkg::CFG_LIGHT_POS0;
    assign cg_idx  = vdl_pkg::CFG_IDX_W'({slot_id, 1'b0}) + vdl_pkg::CFG_LIGHT_CG0;

    // unpack the word
    always_comb
    begin
        vtx[0]  = item_reg.px.vertex_x;
        vtx[1]  = item_reg.px.vertex_y;
        vtx[2]  = item_reg.px.vertex_z;
        nrm[0]  = item_reg.px.normal_x;
        nrm[1]  = item_reg.px.normal_y;
        nrm[2]  = item_reg.px.normal_z;
        base[0] = item_reg.px.base_red;
        base[1] = item_reg.px.base_green;
        base[2] = item_reg.px.base_blue;
        acc[0]  = item_reg.acc_r;
        acc[1]  = item_reg.acc_g;
        acc[2]  = item_reg.acc_b;
    end

    // per-axis and per-channel arithmetic
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            d_c[c]  = {pos_reg[16*c+15], pos_reg[16*c +: 16]} - {vtx[c][15], vtx[c]};
            gp_c[c] = cg_reg[16*c +: 16] * cg_reg[63:48];
            g_c[c]  = gp_c[c][31:12];
            pn_c[c] = nrm[c] * d_reg[c];
            sq_c[c] = d_reg[c] * d_reg[c];
            hp_c[c] = g_reg[c] * quo_reg;
            dp_c[c] = base[c] * h_reg[c];
        end
    end

    // square root step and divide step
    always_comb
    begin
        rem_sh   = {rem_reg[27:0], rad_reg[53:52]};
        trial    = {1'b0, root_reg, 2'b01};
        drem_sh  = {drem_reg[26:0], dvd_reg[17]};
        dividend = {dot_reg[32:0], 11'd0};
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdl_pkg::C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // light registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cg_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pos_idx)
            begin
                pos_reg <= cfg_data[47:0];
            end
            if (cfg_index == cg_idx)
            begin
                cg_reg <= cfg_data;
            end
        end
    end

    // next state and handshake
    always_comb
    begin
        state_next = state_reg;
        up_ready   = 1'b0;
        dn_valid   = 1'b0;
        unique case (state_reg)
            vdl_pkg::C_IDLE:
            begin
                up_ready = 1'b1;
                if (up_valid)
                begin
                    state_next = vdl_pkg::C_DIFF;
                end
            end
            vdl_pkg::C_DIFF: state_next = vdl_pkg::C_PROD;
            vdl_pkg::C_PROD: state_next = vdl_pkg::C_SUM;
            vdl_pkg::C_SUM:  state_next = vdl_pkg::C_CHK;
            vdl_pkg::C_CHK:
            begin
                if (!light_on || dd_reg == '0 || dot_reg <= 0)
                begin
                    state_next = vdl_pkg::C_OUT;
                end
                else
                begin
                    state_next = vdl_pkg::C_SQRT;
                end
            end
            vdl_pkg::C_SQRT:
            begin
                if (cnt_reg == 5'd26)
                begin
                    state_next = vdl_pkg::C_DIVI;
                end
            end
            vdl_pkg::C_DIVI: state_next = vdl_pkg::C_DIV;
            vdl_pkg::C_DIV:
            begin
                if (cnt_reg == 5'd17)
                begin
                    state_next = vdl_pkg::C_HMUL;
                end
            end
            vdl_pkg::C_HMUL: state_next = vdl_pkg::C_DMUL;
            vdl_pkg::C_DMUL: state_next = vdl_pkg::C_OUT;
            vdl_pkg::C_OUT:
            begin
                dn_valid = 1'b1;
                if (dn_ready)
                begin
                    state_next = vdl_pkg::C_IDLE;
                end
            end
            default: state_next = vdl_pkg::C_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            vdl_pkg::C_IDLE:
            begin
                if (up_valid)
                begin
                    item_reg <= up_item;
                end
            end
            vdl_pkg::C_DIFF:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    d_reg[c] <= d_c[c];
                    g_reg[c] <= g_c[c];
                end
            end
            vdl_pkg::C_PROD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pn_reg[c] <= pn_c[c];
                    pd_reg[c] <= sq_c[c][31:0];
                end
            end
            vdl_pkg::C_SUM:
            begin
                dot_reg <= 35'(pn_reg[0]) + 35'(pn_reg[1]) + 35'(pn_reg[2]);
                dd_reg  <= 34'(pd_reg[0]) + 34'(pd_reg[1]) + 34'(pd_reg[2]);
            end
            vdl_pkg::C_CHK:
            begin
                rad_reg  <= {dd_reg, 20'd0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            vdl_pkg::C_SQRT:
            begin
                // one root bit per cycle
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[25:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[25:0], 1'b0};
                end
                rad_reg <= {rad_reg[51:0], 2'b00};
                cnt_reg <= cnt_reg + 5'd1;
            end
            vdl_pkg::C_DIVI:
            begin
                drem_reg <= 28'(dividend[43:18]);
                dvd_reg  <= dividend[17:0];
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            vdl_pkg::C_DIV:
            begin
                // one quotient bit per cycle
                if (drem_sh >= {1'b0, root_reg})
                begin
                    drem_reg <= drem_sh - {1'b0, root_reg};
                    quo_reg  <= {quo_reg[16:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    quo_reg  <= {quo_reg[16:0], 1'b0};
                end
                dvd_reg <= {dvd_reg[16:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            vdl_pkg::C_HMUL:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    h_reg[c] <= hp_c[c][37:15];
                end
            end
            vdl_pkg::C_DMUL:
            begin
                item_reg.acc_r <= acc[0] + vdl_pkg::ACC_W'(dp_c[0][38:15]);
                item_reg.acc_g <= acc[1] + vdl_pkg::ACC_W'(dp_c[1][38:15]);
                item_reg.acc_b <= acc[2] + vdl_pkg::ACC_W'(dp_c[2][38:15]);
            end
            default:
            begin
            end
        endcase
    end

    assign dn_item = item_reg;

    // a light that reaches the divider is never at the vertex
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vdl_pkg::C_DIV |-> root_reg >= 27'd1024)
        else $error("square root below one unit at divide");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vdl_pkg::C_DIV |-> drem_reg < {1'b0, root_reg})
        else $error("divider remainder out of range");

    // cosine quotient fits its headroom
    a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vdl_pkg::C_HMUL |-> quo_reg[17] == 1'b0)
        else $error("cosine quotient overflow");

    // square root runs its full count before the divide
    a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vdl_pkg::C_DIVI |-> $past(cnt_reg) == 5'd26)
        else $error("square root ended early");

endmodule

`default_nettype wire

// File: rtl/core/vertex_diffuse_lighting.sv
// ----------------------------------------------------------------------------
// vertex_diffuse_lighting
// Per-vertex Lambert shading with up to three point lights.
// ----------------------------------------------------------------------------
// Each vertex word passes through a chain of three light cells, one per light
// slot; each cell holds its light's position and color/gain registers and
// adds that light's diffuse term to the running color. A cell skips the square
// root and divide on a disabled, back-facing or coincident light; on a lit one
// it runs setup, a bit-serial square root, a bit-serial divide and its
// multiplies. It hands the word on before it takes the next. The three cells
// work on different vertices at once, so throughput is set by the busiest cell.
// Registers must be written only while the block is empty; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_diffuse_lighting (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [vdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vdl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire vdl_pkg::in_t                    in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output vdl_pkg::out_t                        out_data
);

    logic [1:0] count_reg;

    logic            link_valid [vdl_pkg::LIGHT_SLOTS+1];
    logic            link_ready [vdl_pkg::LIGHT_SLOTS+1];
    vdl_pkg::item_t  link_item  [vdl_pkg::LIGHT_SLOTS+1];

    logic [27:0] amb_r, amb_g, amb_b;
    vdl_pkg::item_t last;

    // light count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we && cfg_index == vdl_pkg::CFG_LIGHT_COUNT)
        begin
            count_reg <= cfg_data[1:0];
        end
    end

    // ambient term seeds the accumulators
    always_comb
    begin
        amb_r = in_data.base_red   * vdl_pkg::AMBIENT_Q15;
        amb_g = in_data.base_green * vdl_pkg::AMBIENT_Q15;
        amb_b = in_data.base_blue  * vdl_pkg::AMBIENT_Q15;
        link_item[0].px    = in_data;
        link_item[0].acc_r = vdl_pkg::ACC_W'(amb_r[27:15]);
        link_item[0].acc_g = vdl_pkg::ACC_W'(amb_g[27:15]);
        link_item[0].acc_b = vdl_pkg::ACC_W'(amb_b[27:15]);
    end

    assign link_valid[0] = in_valid;
    assign in_ready      = link_ready[0];

    // chain of light cells
    for (genvar i = 0; i < vdl_pkg::LIGHT_SLOTS; i++)
    begin : g_cell
        vdl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot_id   (vdl_pkg::SLOT_W'(i)),
            .light_on  (vdl_pkg::SLOT_W'(i) < count_reg),
            .cfg_we    (cfg_we),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .up_valid  (link_valid[i]),
            .up_ready  (link_ready[i]),
            .up_item   (link_item[i]),
            .dn_valid  (link_valid[i+1]),
            .dn_ready  (link_ready[i+1]),
            .dn_item   (link_item[i+1])
        );
    end

    // final clamp to 1.0
    assign last       = link_item[vdl_pkg::LIGHT_SLOTS];
    assign out_valid  = link_valid[vdl_pkg::LIGHT_SLOTS];
    assign link_ready[vdl_pkg::LIGHT_SLOTS] = out_ready;

    always_comb
    begin
        out_data.lit_red   = (last.acc_r > vdl_pkg::ACC_W'(vdl_pkg::ONE_Q15))
                             ? vdl_pkg::ONE_Q15 : last.acc_r[15:0];
        out_data.lit_green = (last.acc_g > vdl_pkg::ACC_W'(vdl_pkg::ONE_Q15))
                             ? vdl_pkg::ONE_Q15 : last.acc_g[15:0];
        out_data.lit_blue  = (last.acc_b > vdl_pkg::ACC_W'(vdl_pkg::ONE_Q15))
                             ? vdl_pkg::ONE_Q15 : last.acc_b[15:0];
    end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vertex diffuse lighting block: a predictor of the
// fixed-point Lambert shading checks every lit color word against the output,
// over several light settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT_CYCLES = 2000000;

    // register indexes
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_COUNT = vdl_pkg::CFG_LIGHT_COUNT;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_POS0  = vdl_pkg::CFG_LIGHT_POS0;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_CG0   = vdl_pkg::CFG_LIGHT_CG0;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_POS1  = 3'd3;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_CG1   = 3'd4;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_POS2  = 3'd5;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_CG2   = 3'd6;
    localparam logic [vdl_pkg::CFG_IDX_W-1:0] REG_NONE  = 3'd7;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [vdl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vdl_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    vdl_pkg::in_t                   in_data;
    logic                           out_valid;
    logic                           out_ready;
    vdl_pkg::out_t                  out_data;

    vertex_diffuse_lighting uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // shadow copy of the light registers
    logic [1:0]  shade_count;
    logic [47:0] shade_pos [vdl_pkg::LIGHT_SLOTS];
    logic [63:0] shade_cg  [vdl_pkg::LIGHT_SLOTS];

    vdl_pkg::in_t  vertex_queue [$];
    vdl_pkg::out_t lit_queue [$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     errors;
    longint cycle_count;

    always #5 clk = ~clk;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v  -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        end
    endfunction

    // lit color for one vertex under the current lights
    function automatic vdl_pkg::out_t shade_vertex(input vdl_pkg::in_t vx);
        longint          vpos [3];
        longint          nrm  [3];
        longint          dl   [3];
        longint unsigned base [3];
        longint unsigned acc  [3];
        longint          dot_sum;
        longint unsigned dist2, len, cosq, inten, lc, g, h;
        int              lights;
        vdl_pkg::out_t   res;
        begin
            vpos[0] = vx.vertex_x;  vpos[1] = vx.vertex_y;  vpos[2] = vx.vertex_z;
            nrm[0]  = vx.normal_x;  nrm[1]  = vx.normal_y;  nrm[2]  = vx.normal_z;
            base[0] = vx.base_red;  base[1] = vx.base_green; base[2] = vx.base_blue;
            for (int c = 0; c < 3; c++)
                acc[c] = (base[c] * 3277) >> 15;
            lights = (shade_count > vdl_pkg::LIGHT_SLOTS) ? vdl_pkg::LIGHT_SLOTS : shade_count;
            for (int li = 0; li < lights; li++)
            begin
                dot_sum = 0;
                dist2   = 0;
                for (int c = 0; c < 3; c++)
                begin
                    dl[c]    = longint'($signed(shade_pos[li][16*c +: 16])) - vpos[c];
                    dot_sum += nrm[c] * dl[c];
                    dist2   += dl[c] * dl[c];
                end
                if (dist2 == 0 || dot_sum <= 0)
                    continue;
                len = root_floor(dist2 << 20);
                if (len == 0)
                    continue;
                cosq  = (longint'(dot_sum) * 2048) / len;
                inten = shade_cg[li][63:48];
                for (int c = 0; c < 3; c++)
                begin
                    lc      = shade_cg[li][16*c +: 16];
                    g       = (lc * inten) >> 12;
                    h       = (g * cosq) >> 15;
                    acc[c] += (base[c] * h) >> 15;
                end
            end
            for (int c = 0; c < 3; c++)
                if (acc[c] > 32768)
                    acc[c] = 32768;
            res.lit_red   = acc[0][15:0];
            res.lit_green = acc[1][15:0];
            res.lit_blue  = acc[2][15:0];
            return res;
        end
    endfunction

    // input handshake tracked on the rising edge
    logic in_took;
    always @(posedge clk)
        in_took <= in_valid && in_ready;

    // driver: present pending vertices
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (vertex_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= vertex_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // predict and retire on the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            lit_queue.push_back(shade_vertex(in_data));
            void'(vertex_queue.pop_front());
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vdl_pkg::out_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (lit_queue.size() == 0)
            begin
                $error("lit word with nothing expected: %h", out_data);
                errors++;
            end
            else
            begin
                want = lit_queue.pop_front();
                if (out_data.lit_red !== want.lit_red)
                begin
                    $error("lit_red expected %0d got %0d", want.lit_red, out_data.lit_red);
                    errors++;
                end
                if (out_data.lit_green !== want.lit_green)
                begin
                    $error("lit_green expected %0d got %0d", want.lit_green,
                           out_data.lit_green);
                    errors++;
                end
                if (out_data.lit_blue !== want.lit_blue)
                begin
                    $error("lit_blue expected %0d got %0d", want.lit_blue, out_data.lit_blue);
                    errors++;
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [vdl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(negedge clk);
            cfg_we    <= 1'b0;
            if (idx == REG_COUNT)
                shade_count = val[1:0];
            else if (idx <= REG_CG2)
            begin
                if (idx[0])
                    shade_pos[(idx - 1) >> 1] = val[47:0];
                else
                    shade_cg[(idx - 1) >> 1] = val;
            end
        end
    endtask

    task automatic drain;
        begin
            while (vertex_queue.size() > 0 || lit_queue.size() > 0 || in_valid)
                @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_q78_near();
        begin
            return 16'($signed($urandom_range(4096)) - 2048);
        end
    endfunction

    // random in-range normal, mostly unit length
    function automatic vdl_pkg::in_t rand_vertex(input bit near);
        vdl_pkg::in_t vx;
        real          a, b, c, m;
        begin
            if (near)
            begin
                vx.vertex_x = rand_q78_near();
                vx.vertex_y = rand_q78_near();
                vx.vertex_z = rand_q78_near();
            end
            else
            begin
                vx.vertex_x = 16'($urandom);
                vx.vertex_y = 16'($urandom);
                vx.vertex_z = 16'($urandom);
            end
            if ($urandom_range(3) != 0)
            begin
                a = real'($signed($urandom_range(2000)) - 1000);
                b = real'($signed($urandom_range(2000)) - 1000);
                c = real'($signed($urandom_range(2000)) - 1000);
                m = $sqrt(a*a + b*b + c*c) + 1.0;
                vx.normal_x = 16'($rtoi(a * 16384.0 / m));
                vx.normal_y = 16'($rtoi(b * 16384.0 / m));
                vx.normal_z = 16'($rtoi(c * 16384.0 / m));
            end
            else
            begin
                vx.normal_x = 16'($signed($urandom_range(32768)) - 16384);
                vx.normal_y = 16'($signed($urandom_range(32768)) - 16384);
                vx.normal_z = 16'($signed($urandom_range(32768)) - 16384);
            end
            vx.base_red   = 16'($urandom_range(32768));
            vx.base_green = 16'($urandom_range(32768));
            vx.base_blue  = 16'($urandom_range(32768));
            return vx;
        end
    endfunction

    function automatic logic [47:0] rand_light_pos(input bit near);
        begin
            if (near)
                return {rand_q78_near(), rand_q78_near(), rand_q78_near()};
            return {16'($urandom), 16'($urandom), 16'($urandom)};
        end
    endfunction

    function automatic vdl_pkg::in_t make_vertex(input logic [15:0] x, y, z, nx, ny, nz,
                                                 r, g, b);
        vdl_pkg::in_t vx;
        begin
            vx = '{x, y, z, nx, ny, nz, r, g, b};
            return vx;
        end
    endfunction

    initial
    begin
        vdl_pkg::in_t vx;
        int           phase;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        in_took        = 1'b0;
        errors         = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        shade_count    = '0;
        for (int i = 0; i < vdl_pkg::LIGHT_SLOTS; i++)
        begin
            shade_pos[i] = '0;
            shade_cg[i]  = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ambient only at reset, then extremes with three lights enabled
        vertex_queue.push_back(make_vertex(16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000,
                                           16'h0000, 16'd32768, 16'd0, 16'd65535));
        drain();
        write_reg(REG_POS0, {16'h0000, 16'h0000, 16'h0400});
        write_reg(REG_CG0, {16'hffff, 16'hffff, 16'h8000, 16'h0000});
        write_reg(REG_POS1, {16'h0400, 16'h0000, 16'h0000});
        write_reg(REG_CG1, {16'h1000, 16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_POS2, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(REG_CG2, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_NONE, 64'hdead_beef_dead_beef);
        write_reg(REG_COUNT, 64'd3);
        // light at the vertex, facing away, facing toward, over-unit normal, max color
        vertex_queue.push_back(make_vertex(16'h0400, 16'h0000, 16'h0000, 16'h4000, 16'h0,
                                           16'h0, 16'd32768, 16'd32768, 16'd32768));
        vertex_queue.push_back(make_vertex(16'h0, 16'h0, 16'h0, 16'hc000, 16'hc000, 16'hc000,
                                           16'd32768, 16'd32768, 16'd32768));
        vertex_queue.push_back(make_vertex(16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0,
                                           16'd16384, 16'd100, 16'd1));
        vertex_queue.push_back(make_vertex(16'h0, 16'h0, 16'h0, 16'h4000, 16'h4000, 16'h4000,
                                           16'd32768, 16'd32768, 16'd32768));
        vertex_queue.push_back(make_vertex(16'h8000, 16'h8000, 16'h8000, 16'h4000,
                                           16'h4000, 16'h4000, 16'hffff, 16'hffff, 16'hffff));
        vertex_queue.push_back(make_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'hc000,
                                           16'hc000, 16'hc000, 16'h5555, 16'haaaa, 16'h0));
        vertex_queue.push_back(make_vertex(16'hffff, 16'h0001, 16'h8001, 16'h3fff,
                                           16'hc001, 16'h0001, 16'h7fff, 16'h0001, 16'h8000));
        drain();

        // random phases: light settings times idle patterns
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            write_reg(REG_COUNT, 64'(phase % 4));
            for (int li = 0; li < vdl_pkg::LIGHT_SLOTS; li++)
            begin
                write_reg(3'(REG_POS0 + 2*li), 64'(rand_light_pos(phase % 3 != 2)));
                if (phase == 11)
                    write_reg(3'(REG_CG0 + 2*li), 64'hffff_ffff_ffff_ffff);
                else
                    write_reg(3'(REG_CG0 + 2*li), {16'($urandom_range(16'h2000)),
                                                   16'($urandom_range(32768)),
                                                   16'($urandom_range(32768)),
                                                   16'($urandom_range(32768))});
            end
            for (int k = 0; k < 137; k++)
            begin
                vx = rand_vertex(phase % 3 != 2);
                // sometimes place the vertex right on a light
                if ($urandom_range(15) == 0)
                    {vx.vertex_z, vx.vertex_y, vx.vertex_x} = shade_pos[$urandom_range(2)];
                vertex_queue.push_back(vx);
            end
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
